// ===== rtl/core/mfre_pkg.sv =====
// ----------------------------------------------------------------------------
// Multiply-free range encoder package
// Shared widths, constants, controller states and the command and status
// bundles that join the controller to the datapath.
// ----------------------------------------------------------------------------
package mfre_pkg;

	localparam int CODE_W       = 32;
	localparam int SYM_W        = 8;
	localparam int FREQ_W       = 16;
	localparam int COUNT_W      = 16;
	localparam int FREQ_BITS    = 16;
	localparam int PENDING_BITS = 16;
	localparam int CODE_SHIFT   = 23;
	localparam int CODE_SYM_W   = CODE_W - CODE_SHIFT;
	localparam int PEND_W       = (PENDING_BITS < COUNT_W) ? PENDING_BITS : COUNT_W;
	localparam int NORM_STEPS   = $clog2(CODE_W);
	localparam int NSTEP_W      = $clog2(NORM_STEPS);

	localparam logic [CODE_W-1:0] CODE_TOP = CODE_W'(1) << (CODE_W - 1);
	localparam logic [CODE_W-1:0] CODE_BOT = CODE_W'(1) << CODE_SHIFT;
	localparam logic [SYM_W-1:0]  BYTE_FF  = '1;
	localparam logic [PEND_W-1:0] PEND_MAX = '1;
	localparam logic [FREQ_W-1:0] FREQ_MASK = FREQ_W'((64'd1 << FREQ_BITS) - 64'd1);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_NORM,
		ST_FIT,
		ST_SPLIT,
		ST_UPDATE,
		ST_RENORM,
		ST_PUT_HELD,
		ST_PUT_RUN,
		ST_FIN_START,
		ST_FIN_TEST,
		ST_FIN_STEP,
		ST_FIN_LOOP,
		ST_FIN_HELD,
		ST_DONE
	} mfre_state_t;

	typedef struct packed {
		logic               load;
		logic               norm_try;
		logic [NSTEP_W-1:0] norm_step;
		logic               fit;
		logic               split;
		logic               update;
		logic               shift_low;
		logic               shift_range;
		logic               fin_init;
		logic               fin_step;
		logic               fin_load;
		logic               put_ff;
		logic               push_held;
		logic               push_run;
		logic               hold_set;
		logic               zero_code;
		logic               flush;
		logic               clear;
	} mfre_cmd_t;

	typedef struct packed {
		logic freq_bad;
		logic finish;
		logic range_low;
		logic low_zero;
		logic fin_far;
		logic code_ff;
		logic held_valid;
		logic pend_nz;
		logic can_push;
		logic out_free;
		logic stg_valid;
	} mfre_sts_t;

endpackage

// ===== rtl/core/mfre_if.sv =====
// ----------------------------------------------------------------------------
// Multiply-free range encoder channels
// Valid/ready channels for symbol items going in and coded byte items
// coming out.
// ----------------------------------------------------------------------------
interface mfre_in_if import mfre_pkg::*; ();

	logic              valid;
	logic              ready;
	logic              action;
	logic [FREQ_W-1:0] sym_low;
	logic [FREQ_W-1:0] sym_high;
	logic [FREQ_W-1:0] freq_total;

	modport source (output valid, action, sym_low, sym_high, freq_total, input ready);
	modport sink (input valid, action, sym_low, sym_high, freq_total, output ready);

endinterface

interface mfre_out_if import mfre_pkg::*; ();

	logic               valid;
	logic               ready;
	logic [SYM_W-1:0]   out_byte;
	logic [COUNT_W-1:0] repeat_count;
	logic               last_of_step;
	logic               stream_end;
	logic               pending_overflow;

	modport source (output valid, out_byte, repeat_count, last_of_step, stream_end,
		pending_overflow, input ready);
	modport sink (input valid, out_byte, repeat_count, last_of_step, stream_end,
		pending_overflow, output ready);

endinterface

// ===== rtl/core/mfre_datapath.sv =====
// ----------------------------------------------------------------------------
// Multiply-free range encoder datapath
// Interval registers, frequency scaling, interval split, byte output with
// carry hold-back, end value search, and the staged output register.
// ----------------------------------------------------------------------------
module mfre_datapath import mfre_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  mfre_cmd_t         cmd,
	output mfre_sts_t         sts,
	input  logic              action,
	input  logic [FREQ_W-1:0] sym_low,
	input  logic [FREQ_W-1:0] sym_high,
	input  logic [FREQ_W-1:0] freq_total,
	mfre_out_if.source        coded
);

	localparam int SH_W = $clog2(CODE_W / 2) + 1;
	localparam int CAND_W = CODE_W + CODE_W / 2;

	typedef struct packed {
		logic [SYM_W-1:0]   value;
		logic [COUNT_W-1:0] count;
		logic               fin;
		logic               ovf;
	} mfre_res_t;

	logic [CODE_W-1:0]     low_q;
	logic [CODE_W-1:0]     range_q;
	logic [CODE_W-1:0]     fl_q;
	logic [CODE_W-1:0]     fh_q;
	logic [CODE_W-1:0]     ft_q;
	logic [CODE_W-1:0]     d_q;
	logic [CODE_W-1:0]     end_q;
	logic [CODE_W-2:0]     msk_q;
	logic                  finish_q;
	logic [SYM_W-1:0]      held_q;
	logic                  held_valid_q;
	logic [PEND_W-1:0]     pend_q;
	logic                  ovf_q;
	mfre_res_t             stg_q;
	logic                  stg_valid_q;
	mfre_res_t             out_q;
	logic                  out_last_q;
	logic                  out_valid_q;

	logic [CODE_W-1:0]     smear;
	logic [SH_W-1:0]       sh;
	logic [CAND_W-1:0]     cand;
	logic                  norm_ok;
	logic [CODE_W:0]       diff;
	logic [CODE_W-1:0]     d_fit;
	logic [CODE_W-1:0]     r_new;
	logic [CODE_W-1:0]     s_new;
	logic [CODE_W-1:0]     msk_next;
	logic [CODE_W-1:0]     end_next;
	logic [CODE_SYM_W-1:0] code;
	logic                  carry;
	logic [SYM_W-1:0]      held_out;
	logic [SYM_W-1:0]      run_out;
	logic                  push_val;
	mfre_res_t             res_new;
	logic                  out_free;
	logic                  out_load;

	always_comb begin
		smear = range_q;
		smear = smear | (smear >> 1);
		smear = smear | (smear >> 2);
		smear = smear | (smear >> 4);
		smear = smear | (smear >> 8);
		smear = smear | (smear >> 16);
	end

	assign sh      = SH_W'((CODE_W / 2) >> cmd.norm_step);
	assign cand    = {{(CODE_W / 2){1'b0}}, ft_q} << sh;
	assign norm_ok = (cand[CAND_W-1:CODE_W] == '0) && ((cand[CODE_W-1:0] & ~smear) == '0);

	assign diff  = {1'b0, range_q} - {1'b0, ft_q};
	assign d_fit = diff[CODE_W] ? (range_q - (ft_q >> 1)) : diff[CODE_W-1:0];

	assign r_new = fh_q + ((fh_q < d_q) ? fh_q : d_q);
	assign s_new = fl_q + ((fl_q < d_q) ? fl_q : d_q);

	assign msk_next = {2'b00, msk_q[CODE_W-2:1]};
	assign end_next = ((low_q + msk_next) & ~msk_next) | (msk_next + CODE_W'(1));

	assign code     = cmd.zero_code ? '0 : low_q[CODE_W-1:CODE_SHIFT];
	assign carry    = code[SYM_W];
	assign held_out = held_q + {{(SYM_W-1){1'b0}}, carry};
	assign run_out  = BYTE_FF + {{(SYM_W-1){1'b0}}, carry};

	assign push_val      = cmd.push_held | cmd.push_run;
	assign res_new.value = cmd.push_held ? held_out : run_out;
	assign res_new.count = cmd.push_held ? COUNT_W'(1) : COUNT_W'(pend_q);
	assign res_new.fin   = finish_q;
	assign res_new.ovf   = ovf_q;

	assign out_free = !out_valid_q || coded.ready;
	assign out_load = (push_val || cmd.flush) && stg_valid_q;

	assign sts.freq_bad   = (ft_q == '0) || (fl_q >= fh_q) || (fh_q > ft_q);
	assign sts.finish     = finish_q;
	assign sts.range_low  = range_q <= CODE_BOT;
	assign sts.low_zero   = low_q == '0;
	assign sts.fin_far    = (end_q - low_q) >= range_q;
	assign sts.code_ff    = code == {1'b0, BYTE_FF};
	assign sts.held_valid = held_valid_q;
	assign sts.pend_nz    = pend_q != '0;
	assign sts.can_push   = !stg_valid_q || out_free;
	assign sts.out_free   = out_free;
	assign sts.stg_valid  = stg_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q        <= '0;
			range_q      <= CODE_TOP;
			held_q       <= '0;
			held_valid_q <= 1'b0;
			pend_q       <= '0;
			ovf_q        <= 1'b0;
			stg_valid_q  <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cmd.clear) begin
				low_q        <= '0;
				range_q      <= CODE_TOP;
				held_q       <= '0;
				held_valid_q <= 1'b0;
				pend_q       <= '0;
				ovf_q        <= 1'b0;
			end else begin
				if (cmd.update) begin
					low_q   <= low_q + fl_q;
					range_q <= fh_q - fl_q;
				end
				if (cmd.fin_load) begin
					low_q <= end_q;
				end
				if (cmd.shift_low) begin
					low_q <= {1'b0, low_q[CODE_W-SYM_W-2:0], {SYM_W{1'b0}}};
				end
				if (cmd.shift_range) begin
					range_q <= {range_q[CODE_W-SYM_W-1:0], {SYM_W{1'b0}}};
				end
				if (cmd.put_ff) begin
					if (pend_q != PEND_MAX) begin
						pend_q <= pend_q + PEND_W'(1);
					end else begin
						ovf_q <= 1'b1;
					end
				end
				if (cmd.hold_set) begin
					held_q       <= code[SYM_W-1:0];
					held_valid_q <= 1'b1;
					pend_q       <= '0;
				end
			end
			if (push_val) begin
				stg_valid_q <= 1'b1;
			end else if (cmd.flush) begin
				stg_valid_q <= 1'b0;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (coded.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			fl_q     <= CODE_W'(sym_low & FREQ_MASK);
			fh_q     <= CODE_W'(sym_high & FREQ_MASK);
			ft_q     <= CODE_W'(freq_total & FREQ_MASK);
			finish_q <= action;
		end
		if (cmd.norm_try && norm_ok) begin
			fl_q <= fl_q << sh;
			fh_q <= fh_q << sh;
			ft_q <= ft_q << sh;
		end
		if (cmd.fit) begin
			d_q <= d_fit;
			if (diff[CODE_W]) begin
				fl_q <= fl_q >> 1;
				fh_q <= fh_q >> 1;
				ft_q <= ft_q >> 1;
			end
		end
		if (cmd.split) begin
			fl_q <= s_new;
			fh_q <= r_new;
		end
		if (cmd.fin_init) begin
			end_q <= CODE_TOP;
			msk_q <= '1;
		end
		if (cmd.fin_step) begin
			end_q <= end_next;
			msk_q <= msk_next[CODE_W-2:0];
		end
		if (push_val) begin
			stg_q <= res_new;
		end
		if (out_load) begin
			out_q      <= stg_q;
			out_last_q <= cmd.flush;
		end
	end

	assign coded.valid            = out_valid_q;
	assign coded.out_byte         = out_q.value;
	assign coded.repeat_count     = out_q.count;
	assign coded.last_of_step     = out_last_q;
	assign coded.stream_end       = out_q.fin;
	assign coded.pending_overflow = out_q.ovf;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> out_free)
		else $error("A waiting result was overwritten.");

	a_range_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		range_q != '0)
		else $error("The interval range collapsed to zero.");

	a_run_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push_run |-> pend_q != '0)
		else $error("An empty run of 0xFF bytes was emitted.");

	a_held_present: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push_held |-> held_valid_q)
		else $error("A held byte was emitted while none was held.");

	a_clear_state: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear |=> (low_q == '0) && !held_valid_q && (pend_q == '0) && !ovf_q)
		else $error("The finish did not return the coder to its start state.");

endmodule

// ===== rtl/core/mfre_ctrl.sv =====
// ----------------------------------------------------------------------------
// Multiply-free range encoder controller
// Sequences one item at a time through scaling, split, byte output and the
// finishing flush, and issues commands to the datapath.
// ----------------------------------------------------------------------------
module mfre_ctrl import mfre_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      item_valid,
	output logic      item_ready,
	input  mfre_sts_t sts,
	output mfre_cmd_t cmd
);

	typedef enum logic [1:0] {
		RET_ENC,
		RET_FIN,
		RET_ZERO
	} mfre_ret_t;

	mfre_state_t        state_q;
	mfre_state_t        state_d;
	mfre_ret_t          ret_q;
	mfre_ret_t          ret_d;
	logic [NSTEP_W-1:0] step_q;
	logic [NSTEP_W-1:0] step_d;
	mfre_state_t        ret_state;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ret_q   <= RET_ENC;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
			step_q  <= step_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		ret_d         = ret_q;
		step_d        = step_q;
		cmd           = '0;
		cmd.norm_step = step_q;
		cmd.zero_code = (ret_q == RET_ZERO);
		item_ready    = 1'b0;

		case (ret_q)
			RET_ENC: ret_state = ST_RENORM;
			RET_FIN: ret_state = ST_FIN_LOOP;
			default: ret_state = ST_DONE;
		endcase

		case (state_q)
			ST_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (sts.finish) begin
					state_d = ST_FIN_START;
				end else if (sts.freq_bad) begin
					state_d = ST_DONE;
				end else begin
					step_d  = '0;
					state_d = ST_NORM;
				end
			end
			ST_NORM: begin
				cmd.norm_try = 1'b1;
				if (step_q == NSTEP_W'(NORM_STEPS - 1)) begin
					state_d = ST_FIT;
				end else begin
					step_d = step_q + NSTEP_W'(1);
				end
			end
			ST_FIT: begin
				cmd.fit = 1'b1;
				state_d = ST_SPLIT;
			end
			ST_SPLIT: begin
				cmd.split = 1'b1;
				state_d   = ST_UPDATE;
			end
			ST_UPDATE: begin
				cmd.update = 1'b1;
				state_d    = ST_RENORM;
			end
			ST_RENORM: begin
				if (sts.range_low) begin
					ret_d   = RET_ENC;
					state_d = ST_PUT_HELD;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_PUT_HELD: begin
				if (sts.code_ff) begin
					cmd.put_ff      = 1'b1;
					cmd.shift_low   = 1'b1;
					cmd.shift_range = (ret_q == RET_ENC);
					state_d         = ret_state;
				end else if (!sts.held_valid) begin
					state_d = ST_PUT_RUN;
				end else if (sts.can_push) begin
					cmd.push_held = 1'b1;
					state_d       = ST_PUT_RUN;
				end
			end
			ST_PUT_RUN: begin
				if (!sts.pend_nz || sts.can_push) begin
					cmd.push_run    = sts.pend_nz;
					cmd.hold_set    = 1'b1;
					cmd.shift_low   = 1'b1;
					cmd.shift_range = (ret_q == RET_ENC);
					state_d         = ret_state;
				end
			end
			ST_FIN_START: begin
				if (sts.low_zero) begin
					state_d = ST_FIN_HELD;
				end else begin
					cmd.fin_init = 1'b1;
					state_d      = ST_FIN_TEST;
				end
			end
			ST_FIN_TEST: begin
				if (sts.fin_far) begin
					state_d = ST_FIN_STEP;
				end else begin
					cmd.fin_load = 1'b1;
					state_d      = ST_FIN_LOOP;
				end
			end
			ST_FIN_STEP: begin
				cmd.fin_step = 1'b1;
				state_d      = ST_FIN_TEST;
			end
			ST_FIN_LOOP: begin
				if (sts.low_zero) begin
					state_d = ST_FIN_HELD;
				end else begin
					ret_d   = RET_FIN;
					state_d = ST_PUT_HELD;
				end
			end
			ST_FIN_HELD: begin
				if (sts.held_valid) begin
					ret_d   = RET_ZERO;
					state_d = ST_PUT_HELD;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!sts.stg_valid || sts.out_free) begin
					cmd.flush = 1'b1;
					cmd.clear = sts.finish;
					state_d   = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== rtl/core/multiply_free_range_encoder.sv =====
// ----------------------------------------------------------------------------
// Multiply-free range encoder
// Range coder with a piecewise-linear interval split, byte output with a
// held-back byte and a counted run of 0xFF bytes for late carries.
// ----------------------------------------------------------------------------
// Usage:
// Items arrive on the symbol channel. An encode item (action 0) carries the
// cumulative frequencies of one symbol; a finish item (action 1) ends the
// stream. Coded bytes leave on the coded channel as a byte and a repeat
// count; last_of_step marks the final item caused by an input item, and an
// input item that causes none gives no output item at all.
// One item is worked on at a time. An encode item goes through scaling and
// the interval split, with a power-of-two scaling search first, then its
// renormalized bytes one by one, and hands the last result over. A finish
// item runs a setup step, the end value search (up to 31 steps), the flush
// of its bytes and a final flush.
// The next item is taken while the final result still waits in the output
// register. When the receiver stalls, results back up in a stage and the
// output register, and the sequencer waits before producing more.
// Reset, and every finish item, returns the coder to an empty stream with
// the full interval, no held byte and a cleared overflow flag.
// ----------------------------------------------------------------------------
module multiply_free_range_encoder import mfre_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	mfre_in_if.sink   symbol,
	mfre_out_if.source coded
);

	mfre_cmd_t cmd;
	mfre_sts_t sts;
	logic      item_ready;

	mfre_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (symbol.valid),
		.item_ready (item_ready),
		.sts        (sts),
		.cmd        (cmd)
	);

	mfre_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.action     (symbol.action),
		.sym_low    (symbol.sym_low),
		.sym_high   (symbol.sym_high),
		.freq_total (symbol.freq_total),
		.coded      (coded)
	);

	assign symbol.ready = item_ready;

endmodule

// ===== tb/multiply_free_range_encoder_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multiply-free range encoder testbench
// Drives symbol and finish items into the encoder, predicts every coded byte
// run in a cycle-free model of the coder, and compares each run field by
// field. Both sides idle at random in two of the three phases. One long receiver
// hold-off fills the block. A series of top slice symbols builds a long run
// of 0xFF bytes that a later byte releases.
// ----------------------------------------------------------------------------
module multiply_free_range_encoder_test;

	import mfre_pkg::*;

	typedef enum logic [1:0] {
		PH_SLOW_RX,
		PH_SLOW_TX,
		PH_STEADY
	} phase_t;

	typedef struct {
		logic              action;
		logic [FREQ_W-1:0] lo;
		logic [FREQ_W-1:0] hi;
		logic [FREQ_W-1:0] tot;
		phase_t            phase;
	} sym_item_t;

	typedef struct {
		logic [SYM_W-1:0]   code_byte;
		logic [COUNT_W-1:0] count;
		logic               last;
		logic               fin;
		logic               ovf;
	} coded_run_t;

	localparam int HOLD_CYCLES = 400;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic              tx_valid = 1'b0;
	logic              tx_action = 1'b0;
	logic [FREQ_W-1:0] tx_lo = '0;
	logic [FREQ_W-1:0] tx_hi = '0;
	logic [FREQ_W-1:0] tx_tot = '0;
	logic              rx_ready = 1'b0;
	phase_t            cur_phase = PH_SLOW_RX;
	int                hold_left = 0;
	logic              hold_done = 1'b0;

	sym_item_t  symbol_queue[$];
	coded_run_t coded_queue[$];
	coded_run_t step_runs[$];

	logic [CODE_W-1:0]  code_low;
	logic [CODE_W-1:0]  code_range;
	logic [SYM_W-1:0]   held_byte;
	logic               held_ok;
	logic [COUNT_W-1:0] ff_run;
	logic               ff_lost;
	logic               step_fin;

	int fail_count = 0;
	int symbols_taken = 0;
	int finishes_taken = 0;
	int runs_checked = 0;
	int ovf_runs = 0;

	mfre_in_if  sym_ch ();
	mfre_out_if code_ch ();

	assign sym_ch.valid      = tx_valid;
	assign sym_ch.action     = tx_action;
	assign sym_ch.sym_low    = tx_lo;
	assign sym_ch.sym_high   = tx_hi;
	assign sym_ch.freq_total = tx_tot;
	assign code_ch.ready     = rx_ready;

	multiply_free_range_encoder i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.symbol (sym_ch),
		.coded  (code_ch)
	);

	always #5 clk = ~clk;

	function automatic int bit_width(input logic [CODE_W-1:0] v);
		int n;
		n = 0;
		while (v != 0) begin
			n++;
			v >>= 1;
		end
		return n;
	endfunction

	task automatic reset_coder();
		code_low   = '0;
		code_range = CODE_TOP;
		held_byte  = '0;
		held_ok    = 1'b0;
		ff_run     = '0;
		ff_lost    = 1'b0;
	endtask

	task automatic emit_run(input logic [SYM_W-1:0] b, input logic [COUNT_W-1:0] n);
		step_runs.push_back('{b, n, 1'b0, step_fin, ff_lost});
	endtask

	// A byte other than 0xFF releases the held byte and the 0xFF run, with the
	// carry in its ninth bit added to both.
	task automatic put_code(input logic [CODE_SYM_W-1:0] c);
		if (c != CODE_SYM_W'(BYTE_FF)) begin
			if (held_ok) begin
				emit_run(SYM_W'(held_byte + c[CODE_SYM_W-1]), COUNT_W'(1));
			end
			if (ff_run != 0) begin
				emit_run(SYM_W'(BYTE_FF + c[CODE_SYM_W-1]), ff_run);
				ff_run = '0;
			end
			held_byte = c[SYM_W-1:0];
			held_ok   = 1'b1;
		end else if (ff_run < COUNT_W'(PEND_MAX)) begin
			ff_run++;
		end else begin
			ff_lost = 1'b1;
		end
	endtask

	task automatic predict_item(input logic act, input logic [FREQ_W-1:0] lo_in,
		input logic [FREQ_W-1:0] hi_in, input logic [FREQ_W-1:0] tot_in);
		logic [CODE_W-1:0] lo, hi, tot, d, r, s, fin, msk;
		int                nrm;
		coded_run_t        run;
		step_runs.delete();
		step_fin = act;
		lo  = CODE_W'(lo_in & FREQ_MASK);
		hi  = CODE_W'(hi_in & FREQ_MASK);
		tot = CODE_W'(tot_in & FREQ_MASK);
		if (act) begin
			if (code_low != 0) begin
				fin = CODE_TOP;
				if (fin - code_low >= code_range) begin
					msk = CODE_TOP - 1;
					do begin
						msk >>= 1;
						fin = ((code_low + msk) & ~msk) | (msk + 1);
					end while (fin - code_low >= code_range);
				end
				while (fin != 0) begin
					put_code(CODE_SYM_W'(fin >> CODE_SHIFT));
					fin = (fin << 8) & (CODE_TOP - 1);
				end
			end
			if (held_ok) begin
				put_code('0);
			end
			reset_coder();
		end else if (tot != 0 && lo < hi && hi <= tot) begin
			nrm = bit_width(code_range) - bit_width(tot);
			if (nrm < 0) begin
				nrm = 0;
			end
			tot = tot << nrm;
			if (tot > code_range) begin
				tot >>= 1;
				nrm--;
			end
			lo = lo << nrm;
			hi = hi << nrm;
			d = code_range - tot;
			r = hi + ((hi < d) ? hi : d);
			s = lo + ((lo < d) ? lo : d);
			code_low   = code_low + s;
			code_range = r - s;
			while (code_range <= CODE_BOT) begin
				put_code(CODE_SYM_W'(code_low >> CODE_SHIFT));
				code_low   = (code_low << 8) & (CODE_TOP - 1);
				code_range = code_range << 8;
			end
		end
		foreach (step_runs[i]) begin
			run = step_runs[i];
			run.last = (i == step_runs.size() - 1);
			coded_queue.push_back(run);
		end
	endtask

	task automatic add_item(input logic act, input int lo, input int hi, input int tot,
		input phase_t ph);
		symbol_queue.push_back('{act, FREQ_W'(lo), FREQ_W'(hi), FREQ_W'(tot), ph});
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_valid  <= 1'b0;
			cur_phase <= PH_SLOW_RX;
		end else begin
			if (tx_valid && sym_ch.ready) begin
				symbol_queue.delete(0);
			end
			if (!tx_valid || sym_ch.ready) begin
				if (symbol_queue.size() != 0 && $urandom_range(99) >=
					((symbol_queue[0].phase == PH_SLOW_RX) ? 23 :
					(symbol_queue[0].phase == PH_SLOW_TX) ? 76 : 0)) begin
					tx_valid  <= 1'b1;
					tx_action <= symbol_queue[0].action;
					tx_lo     <= symbol_queue[0].lo;
					tx_hi     <= symbol_queue[0].hi;
					tx_tot    <= symbol_queue[0].tot;
					cur_phase <= symbol_queue[0].phase;
				end else begin
					tx_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (!hold_done && cur_phase == PH_STEADY) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		coded_run_t want;
		if (!arst_n) begin
			rx_ready <= 1'b0;
			reset_coder();
		end else begin
			if (code_ch.valid && code_ch.ready) begin
				runs_checked++;
				if (code_ch.pending_overflow === 1'b1) begin
					ovf_runs++;
				end
				if (coded_queue.size() == 0) begin
					fail_count++;
					if (fail_count <= 10) begin
						$display("%t: unexpected run: byte %02h x%0d", $realtime,
							code_ch.out_byte, code_ch.repeat_count);
					end
				end else begin
					want = coded_queue.pop_front();
					if (code_ch.out_byte !== want.code_byte || code_ch.repeat_count !== want.count
						|| code_ch.last_of_step !== want.last || code_ch.stream_end !== want.fin
						|| code_ch.pending_overflow !== want.ovf) begin
						fail_count++;
						if (fail_count <= 10) begin
							$display("%t: mismatch: expected %02h x%0d last %0b end %0b ovf %0b",
								$realtime, want.code_byte, want.count, want.last, want.fin,
								want.ovf);
							$display("%t:           actual   %02h x%0d last %0b end %0b ovf %0b",
								$realtime, code_ch.out_byte, code_ch.repeat_count,
								code_ch.last_of_step, code_ch.stream_end,
								code_ch.pending_overflow);
						end
					end
				end
			end
			if (tx_valid && sym_ch.ready) begin
				if (tx_action) begin
					finishes_taken++;
				end else begin
					symbols_taken++;
				end
				predict_item(tx_action, tx_lo, tx_hi, tx_tot);
			end
			rx_ready <= hold_left == 0 && $urandom_range(99) >=
				((cur_phase == PH_SLOW_RX) ? 76 : (cur_phase == PH_SLOW_TX) ? 23 : 0);
		end
	end

	initial begin
		sym_item_t it;
		int        n;
		int        k;
		int        t;
		int        lo;
		add_item(1'b1, 0, 0, 0, PH_SLOW_RX);
		add_item(1'b0, 0, 0, 0, PH_SLOW_RX);
		add_item(1'b0, 7, 7, 100, PH_SLOW_RX);
		add_item(1'b0, 9, 3, 100, PH_SLOW_RX);
		add_item(1'b0, 1, 200, 100, PH_SLOW_RX);
		add_item(1'b0, 0, 1, 1, PH_SLOW_RX);
		add_item(1'b0, 0, 65535, 65535, PH_SLOW_RX);
		add_item(1'b0, 65534, 65535, 65535, PH_SLOW_RX);
		add_item(1'b0, 0, 1, 65535, PH_SLOW_RX);
		add_item(1'b0, 32767, 32768, 65535, PH_SLOW_RX);
		add_item(1'b0, 65535, 65535, 65535, PH_SLOW_RX);
		add_item(1'b1, 65535, 65535, 65535, PH_SLOW_RX);
		add_item(1'b0, 0, 1, 65535, PH_SLOW_RX);
		add_item(1'b1, 0, 0, 0, PH_SLOW_RX);
		add_item(1'b1, 0, 0, 0, PH_SLOW_RX);
		add_item(1'b0, 1, 2, 2, PH_SLOW_RX);
		for (int i = 0; i < 3; i++) begin
			add_item(1'b0, 65534, 65535, 65535, PH_SLOW_RX);
		end
		add_item(1'b0, 40000, 40001, 65535, PH_SLOW_RX);
		add_item(1'b0, 0, 1, 2, PH_SLOW_RX);
		add_item(1'b1, 0, 0, 0, PH_SLOW_RX);

		// Mostly well-formed symbols over models of mixed size, some skewed to
		// the top of the interval to build long 0xFF runs, plus random finish items and noise.
		for (int p = 0; p < 3; p++) begin
			n = 0;
			while (n < 90) begin
				it.phase = phase_t'(p);
				k = $urandom_range(99);
				if (k < 4) begin
					it.action = 1'b1;
					it.lo     = FREQ_W'($urandom);
					it.hi     = FREQ_W'($urandom);
					it.tot    = FREQ_W'($urandom);
				end else if (k < 10) begin
					it.action = 1'b0;
					it.lo     = FREQ_W'($urandom);
					it.hi     = FREQ_W'($urandom);
					it.tot    = FREQ_W'($urandom);
				end else begin
					it.action = 1'b0;
					case ($urandom_range(3))
						0: t = $urandom_range(65535, 1);
						1: t = $urandom_range(16, 1);
						2: t = (1 << $urandom_range(15)) + $urandom_range(1);
						default: t = $urandom_range(65535, 60000);
					endcase
					if (k < 30) begin
						lo = t - 1 - $urandom_range((t > 4) ? 3 : t - 1);
						it.hi = FREQ_W'(t);
					end else begin
						lo = $urandom_range(t - 1);
						it.hi = FREQ_W'($urandom_range(t, lo + 1));
					end
					it.lo  = FREQ_W'(lo);
					it.tot = FREQ_W'(t);
				end
				if (it.action || (it.tot != 0 && it.lo < it.hi && it.hi <= it.tot)) begin
					n++;
				end
				symbol_queue.push_back(it);
			end
		end

		// Each top slice symbol adds about two 0xFF bytes to the pending run.
		// The bottom slice then releases the run.
		add_item(1'b1, 0, 0, 0, PH_STEADY);
		for (int i = 0; i < 20; i++) begin
			add_item(1'b0, 65534, 65535, 65535, PH_STEADY);
		end
		add_item(1'b0, 0, 1, 65535, PH_STEADY);
		add_item(1'b1, 0, 0, 0, PH_STEADY);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		while (symbol_queue.size() != 0 || coded_queue.size() != 0) begin
			@(negedge clk);
		end
		repeat (300) @(negedge clk);
		if (coded_queue.size() != 0) begin
			fail_count += coded_queue.size();
			$display("%0d expected byte runs never arrived", coded_queue.size());
		end
		$display("Coded %0d symbol items and %0d stream ends into %0d byte runs,",
			symbols_taken, finishes_taken, runs_checked);
		$display("%0d of them after the 0xFF run counter saturated.", ovf_runs);
		if (fail_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	initial begin
		#40_000_000;
		$display("Timed out with %0d items unsent and %0d runs outstanding.",
			symbol_queue.size(), coded_queue.size());
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
